>>> sv/ltps_pkg.sv
package ltps_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SCORE_W    = 18;
    localparam int SUM_W      = (CNT_W + SCORE_W > 30) ? CNT_W + SCORE_W : 30;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_SCORE = 2'd2;

    localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] CFG_NORMAL_X  = 3'd2;
    localparam logic [2:0] CFG_NORMAL_Y  = 3'd3;
    localparam logic [2:0] CFG_SHIFT_FAC = 3'd4;
    localparam logic [2:0] CFG_THRESHOLD = 3'd5;
    localparam logic [2:0] CFG_PENALTY   = 3'd6;

    localparam logic signed [SCORE_W-1:0] ONE_Q16 = SCORE_W'(65536);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MX,
        ST_LD_MY,
        ST_LD_ST,
        ST_SC_MUL,
        ST_SC_READ,
        ST_SC_DIFF,
        ST_SC_EVAL,
        ST_SC_DIV,
        ST_SC_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [30:0] num;
        logic [30:0] den;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIV_STEPS-1:0]  quot;
    } t_div_rsp;

endpackage

>>> sv/ltps_div.sv
module ltps_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ltps_pkg::t_div_req i_req,
    output ltps_pkg::t_div_rsp o_rsp
);
    import ltps_pkg::*;

    logic [31:0]          r_rem;
    logic [DIV_STEPS-1:0] r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_active;
    logic                 r_done;
    logic [30:0]          r_den;

    logic [31:0] sh;
    logic        fits;

    // numerator is below the divisor, so one restoring step per quotient bit
    assign sh   = {r_rem[30:0], 1'b0};
    assign fits = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_active <= 1'b1;
                r_cnt    <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_active) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num};
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_active) begin
            r_rem  <= fits ? (sh - {1'b0, r_den}) : sh;
            r_quot <= {r_quot[DIV_STEPS-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> sv/line_translation_point_scorer_unit.sv
// Point scorer against a translated line. Commands are taken when i_start is
// high and o_busy low; the result beat of a load or score shows on the result
// ports for one cycle with o_result_valid, and the receiver cannot stall it.
// A clear gives no result, a load into a full store gives its result on the
// next cycle, and a load with room makes two passes through the shared
// multiplier, then the store write. A score query passes every stored point
// through a read, a difference and a classify state, and a point in the near
// or penalty band also waits for the 16-step shared divider. Configuration
// writes are always ready and must be made while the block is idle.
module line_translation_point_scorer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_shift_amount,
    output logic        o_result_valid,
    output logic signed [29:0] o_total_score,
    output logic        o_store_full,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ltps_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(268435456);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;

    // configuration
    logic signed [31:0] r_ox, r_oy;
    logic signed [17:0] r_nx, r_ny;
    logic [16:0]        r_sf;
    logic [30:0]        r_thr, r_pen;

    t_state r_state, n_state;

    logic signed [32:0] r_dx, r_dy;
    logic signed [31:0] r_sa;
    logic signed [50:0] r_prod, r_acc;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] prod;

    logic [CNT_W-1:0]   r_count, r_idx;
    logic [31:0]        mem [MAX_POINTS];
    logic signed [31:0] r_rd_data;
    logic signed [33:0] r_e;
    logic               r_near;
    logic signed [SUM_W-1:0] r_sum;

    logic               r_out_valid, r_out_full;
    logic signed [29:0] r_out_score;

    logic               accept, full, last;
    logic signed [51:0] ld_sum;
    logic signed [35:0] ld_dq;
    logic signed [31:0] ld_d;
    logic signed [33:0] shift_s;
    logic signed [33:0] abs_e;
    logic signed [34:0] over_e;
    logic               in_near, in_pen;
    logic signed [SCORE_W-1:0] pt_score;

    t_div_req div_req;
    t_div_rsp div_rsp;

    ltps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign accept      = i_start && (r_state == ST_IDLE);
    assign full        = (r_count == CNT_W'(MAX_POINTS));
    assign last        = ((r_idx + 1'b1) == r_count);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // shared multiplier
    always_comb begin
        unique case (r_state)
            ST_LD_MX: begin
                mul_a = r_dx;
                mul_b = r_nx;
            end
            ST_LD_MY: begin
                mul_a = r_dy;
                mul_b = r_ny;
            end
            default: begin
                mul_a = {r_sa[31], r_sa};
                mul_b = {1'b0, r_sf};
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // load distance: floor by 2^16, then saturate to 32 bits
    always_comb begin
        ld_sum = {r_acc[50], r_acc} + {r_prod[50], r_prod};
        ld_dq  = ld_sum[51:16];
        if (ld_dq > 36'sh0_7FFF_FFFF)
            ld_d = 32'sh7FFF_FFFF;
        else if (ld_dq < -36'sh0_8000_0000)
            ld_d = -32'sh8000_0000;
        else
            ld_d = ld_dq[31:0];
    end

    // score classify
    always_comb begin
        shift_s = r_prod[49:16];
        abs_e   = r_e[33] ? -r_e : r_e;
        over_e  = {r_e[33], r_e} - {4'b0, r_thr};
        in_near = (abs_e < {3'b0, r_thr});
        in_pen  = !over_e[34] && (over_e != '0) && (over_e < {4'b0, r_pen});
        div_req.start = (r_state == ST_SC_EVAL) && (in_near || in_pen);
        div_req.num   = in_near ? abs_e[30:0] : over_e[30:0];
        div_req.den   = in_near ? r_thr : r_pen;
        if (r_near)
            pt_score = ONE_Q16 - {2'b0, div_rsp.quot};
        else
            pt_score = -{2'b0, div_rsp.quot};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority case (i_cmd)
                        CMD_LOAD:  n_state = full ? ST_IDLE : ST_LD_MX;
                        CMD_SCORE: n_state = ST_SC_MUL;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LD_MX:   n_state = ST_LD_MY;
            ST_LD_MY:   n_state = ST_LD_ST;
            ST_LD_ST:   n_state = ST_IDLE;
            ST_SC_MUL:  n_state = (r_count == '0) ? ST_SC_DONE : ST_SC_READ;
            ST_SC_READ: n_state = ST_SC_DIFF;
            ST_SC_DIFF: n_state = ST_SC_EVAL;
            ST_SC_EVAL: begin
                if (in_near || in_pen)
                    n_state = ST_SC_DIV;
                else
                    n_state = last ? ST_SC_DONE : ST_SC_READ;
            end
            ST_SC_DIV: begin
                if (div_rsp.done)
                    n_state = last ? ST_SC_DONE : ST_SC_READ;
            end
            ST_SC_DONE: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox  <= '0;
            r_oy  <= '0;
            r_nx  <= '0;
            r_ny  <= 18'sd65536;
            r_sf  <= 17'd65536;
            r_thr <= 31'd65536;
            r_pen <= 31'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_ox  <= i_cfg_data;
                CFG_ORIGIN_Y:  r_oy  <= i_cfg_data;
                CFG_NORMAL_X:  r_nx  <= i_cfg_data[17:0];
                CFG_NORMAL_Y:  r_ny  <= i_cfg_data[17:0];
                CFG_SHIFT_FAC: r_sf  <= i_cfg_data[16:0];
                CFG_THRESHOLD: r_thr <= i_cfg_data[30:0];
                CFG_PENALTY:   r_pen <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_cmd == CMD_CLEAR)
                            r_count <= '0;
                        if (i_cmd == CMD_LOAD && full)
                            r_out_valid <= 1'b1;
                    end
                end
                ST_LD_ST: begin
                    r_count     <= r_count + 1'b1;
                    r_out_valid <= 1'b1;
                end
                ST_SC_MUL: r_idx <= '0;
                ST_SC_EVAL: begin
                    if (!(in_near || in_pen))
                        r_idx <= r_idx + 1'b1;
                end
                ST_SC_DIV: begin
                    if (div_rsp.done)
                        r_idx <= r_idx + 1'b1;
                end
                ST_SC_DONE: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_dx        <= {i_point_x[31], i_point_x} - {r_ox[31], r_ox};
                    r_dy        <= {i_point_y[31], i_point_y} - {r_oy[31], r_oy};
                    r_sa        <= i_shift_amount;
                    r_out_full  <= full;
                    r_out_score <= '0;
                end
            end
            ST_LD_MX: r_prod <= prod;
            ST_LD_MY: begin
                r_acc  <= r_prod;
                r_prod <= prod;
            end
            ST_LD_ST: begin
                r_out_full  <= 1'b0;
                r_out_score <= '0;
            end
            ST_SC_MUL: begin
                r_prod <= prod;
                r_sum  <= '0;
            end
            ST_SC_DIFF: r_e <= {{2{r_rd_data[31]}}, r_rd_data} - shift_s;
            ST_SC_EVAL: r_near <= in_near;
            ST_SC_DIV: begin
                if (div_rsp.done)
                    r_sum <= r_sum + {{(SUM_W-SCORE_W){pt_score[SCORE_W-1]}}, pt_score};
            end
            ST_SC_DONE: begin
                r_out_full <= 1'b0;
                if (r_sum > SUM_MAX)
                    r_out_score <= SUM_MAX[29:0];
                else if (r_sum < SUM_MIN)
                    r_out_score <= SUM_MIN[29:0];
                else
                    r_out_score <= r_sum[29:0];
            end
            default: ;
        endcase
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LD_ST)
            mem[r_count[ADDR_W-1:0]] <= ld_d;
        r_rd_data <= mem[r_idx[ADDR_W-1:0]];
    end

    assign o_result_valid = r_out_valid;
    assign o_total_score  = r_out_score;
    assign o_store_full   = r_out_full;

endmodule

>>> bench/score_checker.sv
`timescale 1ns / 1ps

module score_checker
    import ltps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_shift_amount,
    input  logic               i_result_valid,
    input  logic signed [29:0] i_total_score,
    input  logic               i_store_full,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    localparam longint UNIT      = 65536;
    localparam longint SUM_CEIL  = 268435456;
    localparam longint DIST_MAX  = 64'sd2147483647;
    localparam longint DIST_MIN  = -64'sd2147483648;
    localparam int     PRINT_CAP = 100;

    typedef struct packed {
        logic signed [29:0] total;
        logic               full;
    } t_result_beat;

    longint origin_x, origin_y, normal_x, normal_y, factor, threshold, penalty;
    int           distances [MAX_POINTS];
    int           stored;
    t_result_beat awaited [$];
    t_result_beat oldest;
    t_result_beat fresh;

    task automatic note_mismatch(input string msg);
        if (o_mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        o_mismatches++;
    endtask

    // signed distance along the normal, saturated to 32 bits
    function automatic longint line_distance(input logic signed [31:0] px,
                                             input logic signed [31:0] py);
        longint d;
        d = ((longint'(px) - origin_x) * normal_x
             + (longint'(py) - origin_y) * normal_y) >>> 16;
        if (d > DIST_MAX) d = DIST_MAX;
        if (d < DIST_MIN) d = DIST_MIN;
        return d;
    endfunction

    function automatic longint band_score(input longint e);
        longint a;
        a = (e < 0) ? -e : e;
        if (threshold > 0 && a < threshold)
            return UNIT - (a * UNIT) / threshold;
        if (penalty > 0 && e > threshold && e < threshold + penalty)
            return -(((e - threshold) * UNIT) / penalty);
        return 0;
    endfunction

    function automatic logic signed [29:0] total_for_shift(input logic signed [31:0] sh);
        longint s;
        longint sum;
        s   = (longint'(sh) * factor) >>> 16;
        sum = 0;
        for (int i = 0; i < stored; i++)
            sum += band_score(longint'(distances[i]) - s);
        if (sum > SUM_CEIL)  sum = SUM_CEIL;
        if (sum < -SUM_CEIL) sum = -SUM_CEIL;
        return sum[29:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            origin_x     = 0;
            origin_y     = 0;
            normal_x     = 0;
            normal_y     = UNIT;
            factor       = UNIT;
            threshold    = UNIT;
            penalty      = UNIT;
            stored       = 0;
            awaited.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ORIGIN_X:  origin_x  = longint'($signed(i_cfg_data));
                    CFG_ORIGIN_Y:  origin_y  = longint'($signed(i_cfg_data));
                    CFG_NORMAL_X:  normal_x  = longint'($signed(i_cfg_data[17:0]));
                    CFG_NORMAL_Y:  normal_y  = longint'($signed(i_cfg_data[17:0]));
                    CFG_SHIFT_FAC: factor    = longint'(i_cfg_data[16:0]);
                    CFG_THRESHOLD: threshold = longint'(i_cfg_data[30:0]);
                    CFG_PENALTY:   penalty   = longint'(i_cfg_data[30:0]);
                    default: ;
                endcase
            end

            if (i_result_valid) begin
                if (awaited.size() == 0) begin
                    note_mismatch($sformatf("result beat with nothing awaited: score %0d full %0b",
                                            i_total_score, i_store_full));
                end else begin
                    oldest = awaited.pop_front();
                    if (i_total_score !== oldest.total)
                        note_mismatch($sformatf("total_score %0d, predicted %0d",
                                                i_total_score, oldest.total));
                    if (i_store_full !== oldest.full)
                        note_mismatch($sformatf("store_full %0b, predicted %0b",
                                                i_store_full, oldest.full));
                end
            end

            if (i_start && !i_busy) begin
                case (i_cmd)
                    CMD_CLEAR: stored = 0;
                    CMD_LOAD: begin
                        fresh.total = '0;
                        if (stored >= MAX_POINTS) begin
                            fresh.full = 1'b1;
                        end else begin
                            distances[stored] = int'(line_distance(i_point_x, i_point_y));
                            stored++;
                            fresh.full = 1'b0;
                        end
                        awaited = {awaited, fresh};
                    end
                    CMD_SCORE: begin
                        fresh.total = total_for_shift(i_shift_amount);
                        fresh.full  = 1'b0;
                        awaited = {awaited, fresh};
                    end
                    default: ;
                endcase
            end
        end
        o_outstanding = awaited.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ltps_pkg::*;

    localparam int         HALF_PERIOD = 10;
    localparam int         STALL_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 16;
    localparam int         SETTLE_GAP  = 8;
    localparam int         TAIL_GAP    = 20;
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_start        = 1'b0;
    logic               o_busy;
    logic [1:0]         i_cmd          = CMD_CLEAR;
    logic signed [31:0] i_point_x      = '0;
    logic signed [31:0] i_point_y      = '0;
    logic signed [31:0] i_shift_amount = '0;
    logic               o_result_valid;
    logic signed [29:0] o_total_score;
    logic               o_store_full;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index    = CFG_ORIGIN_X;
    logic [31:0]        i_cfg_data     = '0;

    int     mismatches;
    int     outstanding;
    int     sender_idle = 0;
    int     quiet_cycles = 0;
    longint cfg_ox = 0, cfg_oy = 0, cfg_nx = 0, cfg_ny = 65536;
    longint cfg_thr = 65536, cfg_pen = 65536;
    longint nx, ny;

    line_translation_point_scorer_unit dut (.*);

    score_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_shift_amount (i_shift_amount),
        .i_result_valid (o_result_valid),
        .i_total_score  (o_total_score),
        .i_store_full   (o_store_full),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one command beat, with random sender gaps in front of it
    task automatic issue(input logic [1:0] cmd, input logic [31:0] px,
                         input logic [31:0] py, input logic [31:0] sh);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start        <= 1'b1;
        i_cmd          <= cmd;
        i_point_x      <= px;
        i_point_y      <= py;
        i_shift_amount <= sh;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [31:0] nrm_x, input logic [31:0] nrm_y,
                                 input logic [31:0] fac, input logic [31:0] thr,
                                 input logic [31:0] pen);
        cfg_ox  = longint'($signed(ox));
        cfg_oy  = longint'($signed(oy));
        cfg_nx  = longint'($signed(nrm_x[17:0]));
        cfg_ny  = longint'($signed(nrm_y[17:0]));
        cfg_thr = longint'(thr[30:0]);
        cfg_pen = longint'(pen[30:0]);
        set_register(CFG_ORIGIN_X, ox);
        set_register(CFG_ORIGIN_Y, oy);
        set_register(CFG_NORMAL_X, nrm_x);
        set_register(CFG_NORMAL_Y, nrm_y);
        set_register(CFG_SHIFT_FAC, fac);
        set_register(CFG_THRESHOLD, thr);
        set_register(CFG_PENALTY, pen);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic pick_normal(output longint px, output longint py);
        case ($urandom_range(7))
            0: begin px = 65536;  py = 0;      end
            1: begin px = 0;      py = 65536;  end
            2: begin px = -65536; py = 0;      end
            3: begin px = 0;      py = -65536; end
            4: begin px = 46341;  py = 46341;  end
            5: begin px = -46341; py = 46341;  end
            6: begin px = 39322;  py = -52429; end
            default: begin
                px = longint'($urandom_range(131072)) - 65536;
                py = longint'($urandom_range(131072)) - 65536;
            end
        endcase
    endtask

    // offset that lands around the near and penalty bands of the current setting
    function automatic longint band_offset();
        longint span;
        span = cfg_thr + cfg_pen;
        if (span > 268435456) span = 268435456;
        return longint'($urandom_range(32'(2 * span))) - span;
    endfunction

    task automatic run_random_phase(input int idle);
        int          roll;
        longint      off;
        logic [31:0] px, py, sh;
        sender_idle = idle;
        issue(CMD_CLEAR, $urandom, $urandom, $urandom);
        repeat (PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                issue(CMD_CLEAR, $urandom, $urandom, $urandom);
            end else if (roll < 14) begin
                issue(CMD_IGNORED, $urandom, $urandom, $urandom);
            end else if (roll < 60) begin
                if ($urandom_range(3) != 0) begin
                    off = band_offset();
                    px  = 32'(cfg_ox + ((cfg_nx * off) >>> 16));
                    py  = 32'(cfg_oy + ((cfg_ny * off) >>> 16));
                end else begin
                    px = $urandom;
                    py = $urandom;
                end
                issue(CMD_LOAD, px, py, $urandom);
            end else begin
                if ($urandom_range(9) < 7) sh = 32'(band_offset());
                else                       sh = $urandom;
                issue(CMD_SCORE, $urandom, $urandom, sh);
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: line y = 0, band of one unit each side
        sender_idle = 0;
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0);
        issue(CMD_IGNORED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        issue(CMD_LOAD, 32'h0, 32'h0, 32'h0);
        issue(CMD_LOAD, 32'h0, 32'h0001_0000, 32'h0);
        issue(CMD_LOAD, 32'h0, 32'hffff_0000, 32'h0);
        issue(CMD_LOAD, 32'h0, 32'h0001_8000, 32'h0);
        issue(CMD_LOAD, 32'h0, 32'h0002_0000, 32'h0);
        issue(CMD_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        issue(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h0);
        issue(CMD_LOAD, 32'h0000_4000, 32'h0000_c000, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0000_8000);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h7fff_ffff);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h8000_0000);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'hffff_ffff);
        issue(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0001_0000);
        drain();

        // extreme origins: two of the three distances saturate high
        apply_setting(32'h8000_0000, 32'h7fff_ffff, 65536, -65536, 65536, 1, 32'h7fff_ffff);
        issue(CMD_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        issue(CMD_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        issue(CMD_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h7fff_ffff);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h8000_0000);
        drain();

        // extreme origins the other way: two of the three distances saturate low, no shift
        apply_setting(32'h7fff_ffff, 32'h8000_0000, 65536, -65536, 0, 32'h7fff_ffff, 1);
        issue(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        issue(CMD_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        issue(CMD_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        issue(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h8000_0000);
        drain();

        // zero normal puts every point on the line
        apply_setting(0, 0, 0, 0, 65536, 65536, 65536);
        issue(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        repeat (4) issue(CMD_LOAD, $urandom, $urandom, $urandom);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'h0001_8000);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'hfffe_8000);
        issue(CMD_SCORE, 32'h0, 32'h0, 32'hfffe_0001);
        issue(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
        drain();

        pick_normal(nx, ny);
        apply_setting($urandom, $urandom, 32'(nx), 32'(ny), 65536, 65536, 65536);
        run_random_phase(0);

        pick_normal(nx, ny);
        apply_setting($urandom, $urandom, 32'(nx), 32'(ny), $urandom_range(65536),
                      $urandom_range(1 << 20, 1), $urandom_range(1 << 20, 1));
        run_random_phase(80);

        pick_normal(nx, ny);
        apply_setting($urandom, $urandom, 32'(nx), 32'(ny), 65536, 1, 1);
        run_random_phase(22);

        pick_normal(nx, ny);
        apply_setting($urandom, $urandom, 32'(nx), 32'(ny), $urandom_range(65536),
                      32'h7fff_ffff, 32'h7fff_ffff);
        run_random_phase(0);

        pick_normal(nx, ny);
        apply_setting($urandom, $urandom, 32'(nx), 32'(ny), 32768,
                      $urandom_range(1 << 18, 1), 32'h7fff_ffff);
        run_random_phase(80);

        pick_normal(nx, ny);
        apply_setting(32'(longint'($urandom_range(1 << 20)) - (1 << 19)),
                      32'(longint'($urandom_range(1 << 20)) - (1 << 19)),
                      32'(nx), 32'(ny), $urandom_range(65536),
                      $urandom_range(1 << 24, 1), $urandom_range(1 << 24, 1));
        run_random_phase(22);

        while (outstanding != 0) @(negedge i_clk);
        repeat (TAIL_GAP) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> line_translation_point_scorer_unit.f
sv/ltps_pkg.sv
sv/ltps_div.sv
sv/line_translation_point_scorer_unit.sv
bench/score_checker.sv
bench/testbench.sv
